### rtl/fdf_pkg.sv
`timescale 1ns / 1ps

package fdf_pkg;

    // Detector phases, as reported on the result stream
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_FREEFALL   = 3'd1,
        PH_IMPACT     = 3'd2,
        PH_PENDING    = 3'd3,
        PH_DISPATCHED = 3'd4
    } phase_t;

    // Register map, word index (byte address / 4)
    typedef enum logic [2:0] {
        REG_FREEFALL_MG   = 3'd0,
        REG_IMPACT_MG     = 3'd1,
        REG_CANCEL_WINDOW = 3'd2,
        REG_FF_TIMEOUT    = 3'd3,
        REG_SETTLE        = 3'd4,
        REG_TILT_LIMIT    = 3'd5,
        REG_GYRO_QUIET    = 3'd6
    } reg_idx_t;

    // Register reset values
    localparam logic [13:0] FREEFALL_MG_RST   = 14'd600;
    localparam logic [13:0] IMPACT_MG_RST     = 14'd2800;
    localparam logic [15:0] CANCEL_WINDOW_RST = 16'd15000;
    localparam logic [15:0] FF_TIMEOUT_RST    = 16'd800;
    localparam logic [15:0] SETTLE_RST        = 16'd1500;
    localparam logic [11:0] TILT_LIMIT_RST    = 12'd450;
    localparam logic [15:0] GYRO_QUIET_RST    = 16'd350;

    // Direct impact from idle needs |a| > 1.25 * impact_mg: 16*|a|^2 > 25*impact^2
    localparam int          HARD_SHIFT = 4;
    localparam logic [32:0] HARD_NUM   = 33'd25;

    // Squared thresholds at reset
    localparam logic [27:0] FREEFALL_SQ_RST = 28'(600 * 600);
    localparam logic [27:0] IMPACT_SQ_RST   = 28'(2800 * 2800);
    localparam logic [32:0] HARD_SQ_RST     = 33'(2800 * 2800 * 25);
    localparam logic [31:0] QUIET_SQ_RST    = 32'(350 * 350);

    // Configuration registers
    typedef struct packed {
        logic [13:0] freefall_mg;
        logic [13:0] impact_mg;
        logic [15:0] cancel_window_ms;
        logic [15:0] freefall_timeout_ms;
        logic [15:0] settle_ms;
        logic [11:0] tilt_limit;
        logic [15:0] gyro_quiet;
    } cfg_t;

    // Squared thresholds derived from the registers
    typedef struct packed {
        logic [27:0] freefall_sq;
        logic [27:0] impact_sq;
        logic [32:0] hard_sq;
        logic [31:0] quiet_sq;
    } cfg_sq_t;

    // Per-sample features handed from the front pipeline to the phase logic
    typedef struct packed {
        logic [29:0]        accel_sq;
        logic [31:0]        gyro_sq;
        logic signed [11:0] pitch;
        logic signed [11:0] roll;
        logic               cancel;
        logic [31:0]        now;
        logic               blink_pending;
        logic               blink_dispatch;
    } feat_t;

    // Result of the phase update, before the seconds conversion
    typedef struct packed {
        phase_t      phase;
        logic        motor_on;
        logic        led_on;
        logic [15:0] left_ms;
    } res_t;

    // Conversion of milliseconds left to whole seconds: (d * 67109) >> 26
    localparam logic [16:0] SEC_RECIP = 17'd67109;
    localparam int          SEC_SHIFT = 26;

endpackage

### rtl/fdf_cfg.sv
`timescale 1ns / 1ps

module fdf_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output fdf_pkg::cfg_t     cfg,
    output fdf_pkg::cfg_sq_t  cfg_sq
);

    fdf_pkg::cfg_t    cfg_reg;
    fdf_pkg::cfg_sq_t sq_reg;
    logic             wr_en;
    logic [27:0]      freefall_sq;
    logic [27:0]      impact_sq;
    logic [32:0]      hard_sq;
    logic [31:0]      quiet_sq;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes, value masked to register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freefall_mg         <= fdf_pkg::FREEFALL_MG_RST;
            cfg_reg.impact_mg           <= fdf_pkg::IMPACT_MG_RST;
            cfg_reg.cancel_window_ms    <= fdf_pkg::CANCEL_WINDOW_RST;
            cfg_reg.freefall_timeout_ms <= fdf_pkg::FF_TIMEOUT_RST;
            cfg_reg.settle_ms           <= fdf_pkg::SETTLE_RST;
            cfg_reg.tilt_limit          <= fdf_pkg::TILT_LIMIT_RST;
            cfg_reg.gyro_quiet          <= fdf_pkg::GYRO_QUIET_RST;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                fdf_pkg::REG_FREEFALL_MG:   cfg_reg.freefall_mg         <= pwdata[13:0];
                fdf_pkg::REG_IMPACT_MG:     cfg_reg.impact_mg           <= pwdata[13:0];
                fdf_pkg::REG_CANCEL_WINDOW: cfg_reg.cancel_window_ms    <= pwdata[15:0];
                fdf_pkg::REG_FF_TIMEOUT:    cfg_reg.freefall_timeout_ms <= pwdata[15:0];
                fdf_pkg::REG_SETTLE:        cfg_reg.settle_ms           <= pwdata[15:0];
                fdf_pkg::REG_TILT_LIMIT:    cfg_reg.tilt_limit          <= pwdata[11:0];
                fdf_pkg::REG_GYRO_QUIET:    cfg_reg.gyro_quiet          <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (paddr[4:2])
            fdf_pkg::REG_FREEFALL_MG:   prdata = 32'(cfg_reg.freefall_mg);
            fdf_pkg::REG_IMPACT_MG:     prdata = 32'(cfg_reg.impact_mg);
            fdf_pkg::REG_CANCEL_WINDOW: prdata = 32'(cfg_reg.cancel_window_ms);
            fdf_pkg::REG_FF_TIMEOUT:    prdata = 32'(cfg_reg.freefall_timeout_ms);
            fdf_pkg::REG_SETTLE:        prdata = 32'(cfg_reg.settle_ms);
            fdf_pkg::REG_TILT_LIMIT:    prdata = 32'(cfg_reg.tilt_limit);
            fdf_pkg::REG_GYRO_QUIET:    prdata = 32'(cfg_reg.gyro_quiet);
            default:                    prdata = 32'd0;
        endcase
    end

    // Squared thresholds; the 1.25x term is built from the registered impact square
    assign freefall_sq = cfg_reg.freefall_mg * cfg_reg.freefall_mg;
    assign impact_sq   = cfg_reg.impact_mg * cfg_reg.impact_mg;
    assign hard_sq     = 33'(sq_reg.impact_sq) * fdf_pkg::HARD_NUM;
    assign quiet_sq    = cfg_reg.gyro_quiet * cfg_reg.gyro_quiet;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg.freefall_sq <= fdf_pkg::FREEFALL_SQ_RST;
            sq_reg.impact_sq   <= fdf_pkg::IMPACT_SQ_RST;
            sq_reg.hard_sq     <= fdf_pkg::HARD_SQ_RST;
            sq_reg.quiet_sq    <= fdf_pkg::QUIET_SQ_RST;
        end
        else
        begin
            sq_reg.freefall_sq <= freefall_sq;
            sq_reg.impact_sq   <= impact_sq;
            sq_reg.hard_sq     <= hard_sq;
            sq_reg.quiet_sq    <= quiet_sq;
        end
    end

    assign cfg    = cfg_reg;
    assign cfg_sq = sq_reg;

endmodule

### rtl/fdf_pre.sv
`timescale 1ns / 1ps

module fdf_pre (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [151:0]    s_tdata,
    output logic            feat_valid,
    input  logic            feat_ready,
    output fdf_pkg::feat_t  feat
);

    // Blink periods: pending 500 ms (on for 250), dispatched 400 ms (on for 200).
    // time mod M: fold the four bytes with 2^(8k) mod M, then divide the
    // 18-bit fold exactly by a reciprocal multiply: (f * R) >> 27.
    localparam logic [8:0]  MOD_P      = 9'd500;
    localparam logic [8:0]  ON_P       = 9'd250;
    localparam logic [8:0]  FOLD_P_B2  = 9'd36;
    localparam logic [8:0]  FOLD_P_B3  = 9'd216;
    localparam logic [18:0] RECIP_P    = 19'd268436;
    localparam logic [8:0]  MOD_D      = 9'd400;
    localparam logic [8:0]  ON_D       = 9'd200;
    localparam logic [8:0]  FOLD_D_B2  = 9'd336;
    localparam logic [8:0]  FOLD_D_B3  = 9'd16;
    localparam logic [18:0] RECIP_D    = 19'd335545;
    localparam int          RECIP_SHIFT = 27;

    function automatic logic [17:0] fold_bytes(input logic [31:0] t,
                                               input logic [8:0]  c2,
                                               input logic [8:0]  c3);
        logic [17:0] acc;
        acc = 18'(t[31:24]) * 18'(c3) + 18'(t[23:16]) * 18'(c2)
            + {2'b00, t[15:8], 8'h00} + 18'(t[7:0]);
        return acc;
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic take1, take2, take3, take4;

    // Stage 1: input register
    logic signed [14:0] ax1_reg, ay1_reg, az1_reg;
    logic signed [15:0] gx1_reg, gy1_reg, gz1_reg;
    logic signed [11:0] pitch1_reg, roll1_reg;
    logic               cancel1_reg;
    logic [31:0]        now1_reg;

    // Stage 2: squares and byte folds
    logic [28:0]        axsq2_reg, aysq2_reg, azsq2_reg;
    logic [30:0]        gxsq2_reg, gysq2_reg, gzsq2_reg;
    logic [17:0]        fp2_reg, fd2_reg;
    logic signed [11:0] pitch2_reg, roll2_reg;
    logic               cancel2_reg;
    logic [31:0]        now2_reg;

    // Stage 3: magnitude sums and blink quotients
    logic [29:0]        acc3_reg;
    logic [31:0]        gyr3_reg;
    logic [17:0]        fp3_reg, fd3_reg;
    logic [9:0]         qp3_reg, qd3_reg;
    logic signed [11:0] pitch3_reg, roll3_reg;
    logic               cancel3_reg;
    logic [31:0]        now3_reg;

    // Stage 4: features
    fdf_pkg::feat_t     feat4_reg;

    logic signed [29:0] axp, ayp, azp;
    logic signed [31:0] gxp, gyp, gzp;
    logic [36:0]        prod_p, prod_d;
    logic [18:0]        rem_p, rem_d;

    // Each stage moves on when the next one is empty or moving
    assign take4    = !v4_reg || feat_ready;
    assign take3    = !v3_reg || take4;
    assign take2    = !v2_reg || take3;
    assign take1    = !v1_reg || take2;
    assign s_tready = take1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (take1)
            begin
                v1_reg <= s_tvalid;
            end
            if (take2)
            begin
                v2_reg <= v1_reg;
            end
            if (take3)
            begin
                v3_reg <= v2_reg;
            end
            if (take4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1 load: unpack the item
    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            ax1_reg     <= s_tdata[14:0];
            ay1_reg     <= s_tdata[29:15];
            az1_reg     <= s_tdata[44:30];
            gx1_reg     <= s_tdata[60:45];
            gy1_reg     <= s_tdata[76:61];
            gz1_reg     <= s_tdata[92:77];
            pitch1_reg  <= s_tdata[104:93];
            roll1_reg   <= s_tdata[116:105];
            cancel1_reg <= s_tdata[117];
            now1_reg    <= s_tdata[149:118];
        end
    end

    // Stage 2: one multiplier deep
    assign axp = ax1_reg * ax1_reg;
    assign ayp = ay1_reg * ay1_reg;
    assign azp = az1_reg * az1_reg;
    assign gxp = gx1_reg * gx1_reg;
    assign gyp = gy1_reg * gy1_reg;
    assign gzp = gz1_reg * gz1_reg;

    always_ff @(posedge clk)
    begin
        if (take2)
        begin
            axsq2_reg   <= axp[28:0];
            aysq2_reg   <= ayp[28:0];
            azsq2_reg   <= azp[28:0];
            gxsq2_reg   <= gxp[30:0];
            gysq2_reg   <= gyp[30:0];
            gzsq2_reg   <= gzp[30:0];
            fp2_reg     <= fold_bytes(now1_reg, FOLD_P_B2, FOLD_P_B3);
            fd2_reg     <= fold_bytes(now1_reg, FOLD_D_B2, FOLD_D_B3);
            pitch2_reg  <= pitch1_reg;
            roll2_reg   <= roll1_reg;
            cancel2_reg <= cancel1_reg;
            now2_reg    <= now1_reg;
        end
    end

    // Stage 3: sums and reciprocal quotients
    assign prod_p = 37'(fp2_reg) * 37'(RECIP_P);
    assign prod_d = 37'(fd2_reg) * 37'(RECIP_D);

    always_ff @(posedge clk)
    begin
        if (take3)
        begin
            acc3_reg    <= 30'(axsq2_reg) + 30'(aysq2_reg) + 30'(azsq2_reg);
            gyr3_reg    <= 32'(gxsq2_reg) + 32'(gysq2_reg) + 32'(gzsq2_reg);
            qp3_reg     <= prod_p[RECIP_SHIFT +: 10];
            qd3_reg     <= prod_d[RECIP_SHIFT +: 10];
            fp3_reg     <= fp2_reg;
            fd3_reg     <= fd2_reg;
            pitch3_reg  <= pitch2_reg;
            roll3_reg   <= roll2_reg;
            cancel3_reg <= cancel2_reg;
            now3_reg    <= now2_reg;
        end
    end

    // Stage 4: remainders and blink phases
    assign rem_p = 19'(fp3_reg) - 19'(qp3_reg) * 19'(MOD_P);
    assign rem_d = 19'(fd3_reg) - 19'(qd3_reg) * 19'(MOD_D);

    always_ff @(posedge clk)
    begin
        if (take4)
        begin
            feat4_reg.accel_sq       <= acc3_reg;
            feat4_reg.gyro_sq        <= gyr3_reg;
            feat4_reg.pitch          <= pitch3_reg;
            feat4_reg.roll           <= roll3_reg;
            feat4_reg.cancel         <= cancel3_reg;
            feat4_reg.now            <= now3_reg;
            feat4_reg.blink_pending  <= (rem_p[8:0] < ON_P);
            feat4_reg.blink_dispatch <= (rem_d[8:0] < ON_D);
        end
    end

    assign feat_valid = v4_reg;
    assign feat       = feat4_reg;

endmodule

### rtl/fdf_core.sv
`timescale 1ns / 1ps

module fdf_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              feat_valid,
    output logic              feat_ready,
    input  fdf_pkg::feat_t    feat,
    input  fdf_pkg::cfg_t     cfg,
    input  fdf_pkg::cfg_sq_t  cfg_sq,
    output logic              res_valid,
    input  logic              res_ready,
    output fdf_pkg::res_t     res
);

    fdf_pkg::phase_t    phase_reg, phase_next;
    logic [31:0]        ff_time_reg, ff_time_next;
    logic [31:0]        impact_time_reg, impact_time_next;
    logic [31:0]        alert_time_reg, alert_time_next;
    logic signed [11:0] ref_pitch_reg, ref_pitch_next;
    logic signed [11:0] ref_roll_reg, ref_roll_next;
    logic               motor_reg, motor_next;
    logic               led_reg, led_next;
    logic [15:0]        left_ms_next;
    logic               res_valid_reg;
    fdf_pkg::res_t      res_reg;

    logic               upd;
    logic               cancel_hit;
    logic [31:0]        el_ff, el_impact, el_alert, el_left;
    logic               ff_expired, settled, window_done;
    logic               hit_freefall, hit_impact, hit_hard, still, tilted;
    logic signed [12:0] d_pitch, d_roll;
    logic [12:0]        a_pitch, a_roll;

    assign feat_ready = !res_valid_reg || res_ready;
    assign upd        = feat_valid && feat_ready;

    // Conditions for this sample
    assign cancel_hit = feat.cancel &&
                        (phase_reg == fdf_pkg::PH_PENDING ||
                         phase_reg == fdf_pkg::PH_DISPATCHED);

    assign el_ff       = feat.now - ff_time_reg;
    assign el_impact   = feat.now - impact_time_reg;
    assign el_alert    = feat.now - alert_time_reg;
    assign ff_expired  = el_ff > 32'(cfg.freefall_timeout_ms);
    assign settled     = el_impact >= 32'(cfg.settle_ms);
    assign window_done = el_alert >= 32'(cfg.cancel_window_ms);

    assign hit_freefall = feat.accel_sq < 30'(cfg_sq.freefall_sq);
    assign hit_impact   = feat.accel_sq > 30'(cfg_sq.impact_sq);
    assign hit_hard     = {feat.accel_sq, {fdf_pkg::HARD_SHIFT{1'b0}}} > 34'(cfg_sq.hard_sq);
    assign still        = feat.gyro_sq < cfg_sq.quiet_sq;

    // Tilt against the reference taken in idle
    assign d_pitch = $signed({feat.pitch[11], feat.pitch}) -
                     $signed({ref_pitch_reg[11], ref_pitch_reg});
    assign d_roll  = $signed({feat.roll[11], feat.roll}) -
                     $signed({ref_roll_reg[11], ref_roll_reg});
    assign a_pitch = d_pitch[12] ? 13'(-d_pitch) : 13'(d_pitch);
    assign a_roll  = d_roll[12] ? 13'(-d_roll) : 13'(d_roll);
    assign tilted  = (a_pitch > 13'(cfg.tilt_limit)) || (a_roll > 13'(cfg.tilt_limit));

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (cancel_hit)
        begin
            phase_next = fdf_pkg::PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                fdf_pkg::PH_FREEFALL:
                begin
                    if (ff_expired)
                    begin
                        phase_next = fdf_pkg::PH_IDLE;
                    end
                    else if (hit_impact)
                    begin
                        phase_next = fdf_pkg::PH_IMPACT;
                    end
                end
                fdf_pkg::PH_IMPACT:
                begin
                    if (settled)
                    begin
                        phase_next = (tilted && still) ? fdf_pkg::PH_PENDING
                                                       : fdf_pkg::PH_IDLE;
                    end
                end
                fdf_pkg::PH_PENDING:
                begin
                    if (window_done)
                    begin
                        phase_next = fdf_pkg::PH_DISPATCHED;
                    end
                end
                fdf_pkg::PH_DISPATCHED:
                begin
                    phase_next = fdf_pkg::PH_DISPATCHED;
                end
                default:
                begin
                    // idle, and any stray code behaves as idle
                    if (hit_freefall)
                    begin
                        phase_next = fdf_pkg::PH_FREEFALL;
                    end
                    else if (hit_hard)
                    begin
                        phase_next = fdf_pkg::PH_IMPACT;
                    end
                    else
                    begin
                        phase_next = fdf_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

    // Timestamps, reference tilt, drives and time left
    always_comb
    begin
        ff_time_next     = ff_time_reg;
        impact_time_next = impact_time_reg;
        alert_time_next  = alert_time_reg;
        ref_pitch_next   = ref_pitch_reg;
        ref_roll_next    = ref_roll_reg;
        motor_next       = motor_reg;
        led_next         = led_reg;
        left_ms_next     = 16'd0;
        if (cancel_hit)
        begin
            motor_next = 1'b0;
            led_next   = 1'b0;
        end
        else
        begin
            case (phase_reg)
                fdf_pkg::PH_FREEFALL:
                begin
                    if (!ff_expired && hit_impact)
                    begin
                        impact_time_next = feat.now;
                    end
                end
                fdf_pkg::PH_IMPACT:
                begin
                    if (settled && tilted && still)
                    begin
                        alert_time_next = feat.now;
                    end
                end
                fdf_pkg::PH_PENDING:
                begin
                    motor_next = feat.blink_pending;
                    led_next   = feat.blink_pending;
                end
                fdf_pkg::PH_DISPATCHED:
                begin
                    motor_next = feat.blink_dispatch;
                    led_next   = 1'b1;
                end
                default:
                begin
                    ref_pitch_next = feat.pitch;
                    ref_roll_next  = feat.roll;
                    if (hit_freefall)
                    begin
                        ff_time_next = feat.now;
                    end
                    else if (hit_hard)
                    begin
                        impact_time_next = feat.now;
                    end
                end
            endcase
        end
        el_left = feat.now - alert_time_next;
        if (phase_next == fdf_pkg::PH_PENDING && el_left < 32'(cfg.cancel_window_ms))
        begin
            left_ms_next = cfg.cancel_window_ms - el_left[15:0];
        end
    end

    // State update, once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= fdf_pkg::PH_IDLE;
            ff_time_reg     <= 32'd0;
            impact_time_reg <= 32'd0;
            alert_time_reg  <= 32'd0;
            ref_pitch_reg   <= 12'sd0;
            ref_roll_reg    <= 12'sd0;
            motor_reg       <= 1'b0;
            led_reg         <= 1'b0;
        end
        else if (upd)
        begin
            phase_reg       <= phase_next;
            ff_time_reg     <= ff_time_next;
            impact_time_reg <= impact_time_next;
            alert_time_reg  <= alert_time_next;
            ref_pitch_reg   <= ref_pitch_next;
            ref_roll_reg    <= ref_roll_next;
            motor_reg       <= motor_next;
            led_reg         <= led_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (feat_ready)
        begin
            res_valid_reg <= feat_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            res_reg.phase    <= phase_next;
            res_reg.motor_on <= motor_next;
            res_reg.led_on   <= led_next;
            res_reg.left_ms  <= left_ms_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef ASSERT_OFF
    a_cancel_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        upd && cancel_hit |=> phase_reg == fdf_pkg::PH_IDLE && !motor_reg && !led_reg)
        else $error("cancel in pending or dispatched did not return to idle");

    a_hold_without_item: assert property (@(posedge clk) disable iff (!rst_n)
        !upd |=> $stable(phase_reg) && $stable(alert_time_reg) && $stable(motor_reg))
        else $error("detector state changed without an item");

    a_impact_exits: assert property (@(posedge clk) disable iff (!rst_n)
        upd && phase_reg == fdf_pkg::PH_IMPACT |=>
            phase_reg != fdf_pkg::PH_FREEFALL && phase_reg != fdf_pkg::PH_DISPATCHED)
        else $error("illegal exit from impact phase");

    a_time_left_pending: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.left_ms != 16'd0 |-> res_reg.phase == fdf_pkg::PH_PENDING)
        else $error("time left reported outside pending phase");
`endif

endmodule

### rtl/fdf_out.sv
`timescale 1ns / 1ps

module fdf_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    output logic           res_ready,
    input  fdf_pkg::res_t  res,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata
);

    logic            v_reg;
    logic            take;
    fdf_pkg::phase_t phase_reg;
    logic            motor_reg;
    logic            led_reg;
    logic [6:0]      secs_reg;
    logic [32:0]     secs_prod;

    assign take      = !v_reg || m_tready;
    assign res_ready = take;

    // Milliseconds left to whole seconds, exact for 16-bit inputs
    assign secs_prod = 33'(res.left_ms) * 33'(fdf_pkg::SEC_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (take)
        begin
            v_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            phase_reg <= res.phase;
            motor_reg <= res.motor_on;
            led_reg   <= res.led_on;
            secs_reg  <= secs_prod[fdf_pkg::SEC_SHIFT +: 7];
        end
    end

    assign m_tvalid = v_reg;
    assign m_tdata  = {4'b0000, secs_reg, led_reg, motor_reg, phase_reg};

endmodule

### rtl/fall_detector_fsm.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        one motion sample per item
// m_*       out        m_tvalid / m_tready        one detector result per item
// APB       in         psel, penable, pwrite      7 threshold registers, 4-byte stride
//
// One item per clock sustained while m_tready is high; a result is offered on m_*
// after its sample passes the input register, 3 further front stages for squares
// and blink timing, 1 phase update stage and 1 seconds conversion stage.
// The phase update is the only loop: one compare layer and a mux per item.
// Reset (rst_n low, async) empties the pipeline, sets the phase to idle,
// clears timestamps, reference tilt and drives, and loads default thresholds.
// A stalled output holds its stage; earlier stages keep filling until full.

module fall_detector_fsm (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // accel_x[14:0] accel_y[29:15] accel_z[44:30] gyro_x[60:45] gyro_y[76:61]
    // gyro_z[92:77] pitch[104:93] roll[116:105] cancel_pressed[117]
    // time_ms[149:118], zero pad [151:150]
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // phase[2:0] motor_on[3] led_on[4] remaining_seconds[11:5], zero pad [15:12]
    output logic [15:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    fdf_pkg::cfg_t    cfg;
    fdf_pkg::cfg_sq_t cfg_sq;
    fdf_pkg::feat_t   feat;
    fdf_pkg::res_t    res;
    logic             feat_valid;
    logic             feat_ready;
    logic             res_valid;
    logic             res_ready;

    fdf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_sq  (cfg_sq)
    );

    fdf_pre u_pre (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .feat_valid (feat_valid),
        .feat_ready (feat_ready),
        .feat       (feat)
    );

    fdf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .feat_valid (feat_valid),
        .feat_ready (feat_ready),
        .feat       (feat),
        .cfg        (cfg),
        .cfg_sq     (cfg_sq),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    fdf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
